>>> hdl/skt_pkg.sv
// Shared constants and types for the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BITS    = 32;
  localparam int DEF_RECORD_BITS = 64;

  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 64;
  localparam int POS_W     = 10;
  localparam int STATUS_W  = 3;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND       = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_OVERWRITTEN = 3'd3,
    ST_UNCHANGED   = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

  typedef struct packed {
    logic done;
    logic hit;
  } srch_stat_t;

endpackage

>>> hdl/skt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/skt_search.sv
// Binary search unit: each probe of the record RAM passes through a probe state and a compare state.
`timescale 1ns / 1ps
module skt_search import skt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int RECORD_BITS = DEF_RECORD_BITS,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int REC_W = KEY_BITS + RECORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [KEY_BITS-1:0]    key_in,
  input  logic [CNT_W-1:0]       count,
  output logic [IDX_W-1:0]       rd_addr,
  input  logic [REC_W-1:0]       rd_rec,
  output srch_stat_t             stat,
  output logic [CNT_W-1:0]       slot,
  output logic [RECORD_BITS-1:0] hit_payload
);

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP} state_t;

  state_t             state;
  logic [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]   lo;
  logic [CNT_W-1:0]   hi;
  logic [CNT_W-1:0]   mid;
  logic [IDX_W-1:0]   mid_q;
  logic [KEY_BITS-1:0] rd_key;

  assign mid     = lo + ((hi - lo) >> 1);
  assign rd_addr = mid[IDX_W-1:0];
  assign rd_key  = rd_rec[REC_W-1:RECORD_BITS];

  always_ff @(posedge clk) begin
    stat.done <= 1'b0;
    if (rst) begin
      state    <= S_IDLE;
      stat.hit <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (go) begin
            key_q <= key_in;
            lo    <= '0;
            hi    <= count;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid_q <= mid[IDX_W-1:0];
            state <= S_CMP;
          end else begin
            stat.done <= 1'b1;
            stat.hit  <= 1'b0;
            slot      <= lo;
            state     <= S_IDLE;
          end
        end
        S_CMP: begin
          if (key_q > rd_key) begin
            lo    <= CNT_W'(mid_q) + 1'b1;
            state <= S_PROBE;
          end else if (key_q < rd_key) begin
            hi    <= CNT_W'(mid_q);
            state <= S_PROBE;
          end else begin
            stat.done   <= 1'b1;
            stat.hit    <= 1'b1;
            slot        <= CNT_W'(mid_q);
            hit_payload <= rd_rec[RECORD_BITS-1:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/sorted_key_table_insert_lookup.sv
// Top level: request sequencer, entry shifter and result register.
// A lookup probes the record RAM through its one read port, each probe passing
// through a probe state and a compare state. An insert of a new key then moves
// the entries from the slot upward, one RAM read and write per moved entry.
// One request at a time: busy stays high from acceptance until done pulses.
// Reset empties the table (count to zero) and idles the sequencers; no RAM clear.
`timescale 1ns / 1ps
module sorted_key_table_insert_lookup import skt_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS,
  parameter int RECORD_BITS = DEF_RECORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [KEY_W-1:0]     key,
  input  logic [PAYLOAD_W-1:0] payload,
  input  logic                 overwrite,
  output logic                 done,
  output logic [STATUS_W-1:0]  status,
  output logic [POS_W-1:0]     position,
  output logic                 modified,
  output logic                 length_increased,
  output logic [PAYLOAD_W-1:0] found_payload
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int REC_W = KEY_BITS + RECORD_BITS;

  typedef enum logic [1:0] {T_IDLE, T_SEARCH, T_SHIFT, T_PLACE} state_t;

  state_t                 state;
  logic                   req_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [RECORD_BITS-1:0] pay_q;
  logic                   ovw_q;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       slot_q;
  logic [CNT_W-1:0]       left;
  logic [IDX_W-1:0]       src;
  logic                   pend;
  logic [IDX_W-1:0]       pend_addr;
  status_t                status_q;

  logic                   accept;
  logic [KEY_BITS-1:0]    key_in;
  srch_stat_t             s_stat;
  logic [CNT_W-1:0]       s_slot;
  logic [RECORD_BITS-1:0] s_pay;
  logic [IDX_W-1:0]       s_addr;
  logic                   ovw_hit;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [REC_W-1:0]       wdata;
  logic [IDX_W-1:0]       raddr;
  logic [REC_W-1:0]       rdata;

  assign accept  = start && !busy;
  assign key_in  = KEY_BITS'(key);
  assign busy    = (state != T_IDLE);
  assign status  = status_q;
  assign ovw_hit = (state == T_SEARCH) && s_stat.done && s_stat.hit &&
                   (req_q == REQ_INSERT) && ovw_q && (s_pay != pay_q);

  skt_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .RECORD_BITS (RECORD_BITS)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .go          (accept),
    .key_in      (key_in),
    .count       (count),
    .rd_addr     (s_addr),
    .rd_rec      (rdata),
    .stat        (s_stat),
    .slot        (s_slot),
    .hit_payload (s_pay)
  );

  skt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    raddr = (state == T_SHIFT) ? src : s_addr;
    we    = 1'b0;
    waddr = slot_q;
    wdata = {key_q, pay_q};
    if (state == T_SHIFT && pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else if (state == T_PLACE) begin
      we = 1'b1;
    end else if (ovw_hit) begin
      we    = 1'b1;
      waddr = s_slot[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= T_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            req_q <= req_type;
            key_q <= key_in;
            pay_q <= RECORD_BITS'(payload);
            ovw_q <= overwrite;
            state <= T_SEARCH;
          end
        end
        T_SEARCH: begin
          if (s_stat.done) begin
            modified         <= 1'b0;
            length_increased <= 1'b0;
            found_payload    <= '0;
            position         <= '0;
            state            <= T_IDLE;
            if (req_q == REQ_LOOKUP) begin
              done <= 1'b1;
              if (s_stat.hit) begin
                status_q      <= ST_FOUND;
                position      <= POS_W'(s_slot);
                found_payload <= PAYLOAD_W'(s_pay);
              end else begin
                status_q <= ST_NOT_FOUND;
              end
            end else if (s_stat.hit) begin
              done     <= 1'b1;
              position <= POS_W'(s_slot);
              if (ovw_hit) begin
                status_q <= ST_OVERWRITTEN;
                modified <= 1'b1;
              end else begin
                status_q <= ST_UNCHANGED;
              end
            end else if (count == CNT_W'(TABLE_DEPTH)) begin
              done     <= 1'b1;
              status_q <= ST_FULL;
            end else begin
              slot_q <= s_slot[IDX_W-1:0];
              left   <= count - s_slot;
              src    <= IDX_W'(count - 1'b1);
              pend   <= 1'b0;
              state  <= T_SHIFT;
            end
          end
        end
        T_SHIFT: begin
          if (left != '0) begin
            pend      <= 1'b1;
            pend_addr <= src + 1'b1;
            src       <= src - 1'b1;
            left      <= left - 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= T_PLACE;
          end
        end
        T_PLACE: begin
          count            <= count + 1'b1;
          done             <= 1'b1;
          status_q         <= ST_INSERTED;
          position         <= POS_W'(slot_q);
          modified         <= 1'b1;
          length_increased <= 1'b1;
          found_payload    <= '0;
          state            <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/skt_checker.sv
// Port-level checker for the sorted key table, bound to the top level.
`timescale 1ns / 1ps
module skt_checker import skt_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [STATUS_W-1:0]  status,
  input logic [POS_W-1:0]     position,
  input logic                 modified,
  input logic                 length_increased,
  input logic [PAYLOAD_W-1:0] found_payload
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !$past(done))
    else $error("result beat without a request in flight");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOT_FOUND || status == ST_FULL)) |->
      (position == '0) && (found_payload == '0) && !modified && !length_increased)
    else $error("miss or full result carries data");

  a_grow_flags: assert property (@(posedge clk) disable iff (rst)
    (done && length_increased) |-> modified && (status == ST_INSERTED))
    else $error("growth flag without insert status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= ST_FULL))
    else $error("status code out of range");

endmodule

bind sorted_key_table_insert_lookup skt_checker u_skt_checker (.*);
